### hdl/fic_pkg.sv
// fic_pkg: constants, types and the coefficient rom of the fir interpolator unit.
// the coefficient table is built at elaboration by fixed-point integer functions.
// no dependencies.
`timescale 1ns / 1ps

package fic_pkg;

   localparam int TAPS              = 32;
   localparam int OVERSAMPLE_FACTOR = 4;
   localparam int CUTOFF_HZ         = 20000;
   localparam int OUTPUT_RATE_HZ    = 192000;

   localparam int HIST_DEPTH = (TAPS + OVERSAMPLE_FACTOR - 1) / OVERSAMPLE_FACTOR;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int SCALED_W   = SAMPLE_W + $clog2(OVERSAMPLE_FACTOR);
   localparam int PROD_W     = SCALED_W + COEF_W;
   localparam int ACC_W      = PROD_W + $clog2(HIST_DEPTH) + 1;
   localparam int PHASE_W    = $clog2(OVERSAMPLE_FACTOR);
   localparam int TAP_W      = $clog2(HIST_DEPTH * OVERSAMPLE_FACTOR + OVERSAMPLE_FACTOR);
   localparam int ROM_AW     = $clog2(TAPS);
   localparam int FRAC_SHIFT = 16;

   localparam longint Q30_ONE    = 64'sd1073741824;
   localparam longint TWO_PI_Q30 = 64'sd6746518852;
   localparam longint INV_PI_Q30 = 64'sd341782638;
   localparam longint WIN_A_Q30  = 64'sd579820585;
   localparam longint WIN_B_Q30  = 64'sd493921239;
   localparam longint TURN_ONE   = 64'sd4294967296;
   localparam longint COEF_MAX   = 64'sd131071;
   localparam longint COEF_MIN   = -64'sd131072;

   // center tap of the sinc, twice the normalized cutoff in q30
   localparam longint SINC_CENTER =
      64'sd2 * longint'(CUTOFF_HZ) * Q30_ONE / longint'(OUTPUT_RATE_HZ);

   typedef logic signed [COEF_W-1:0] coef_rom_type [TAPS];

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                    valid;
      logic [TAP_W-1:0]        tap;
      logic                    last;
      logic                    eob;
      logic signed [ACC_W-1:0] acc;
   } chain_type;

   // unsigned truncating quotient by shift and subtract, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // signed quotient truncated toward zero
   function automatic longint sdiv(input longint num, input longint den);
      logic        neg;
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      neg = (num < 0) != (den < 0);
      un  = (num < 0) ? 64'(-num) : 64'(num);
      ud  = (den < 0) ? 64'(-den) : 64'(den);
      q   = udiv(un, ud);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // q30 product with magnitudes rounded and sign restored
   function automatic longint qmul(input longint a, input longint b);
      logic neg;
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? 64'(-a) : 64'(a);
      ub  = (b < 0) ? 64'(-b) : 64'(b);
      p   = (ua * ub + (64'd1 << 29)) >> 30;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   // sine of an angle in turns, 2^-32 units, result in q30
   function automatic longint sin_turn(input int unsigned ph);
      int unsigned r;
      longint s;
      longint x;
      longint x2;
      longint t;
      r = ph;
      if (r >= 32'h4000_0000 && r < 32'hC000_0000) begin
         r = 32'h8000_0000 - r;
      end
      s  = (r >= 32'h8000_0000) ? longint'(r) - TURN_ONE : longint'(r);
      x  = sdiv(s * TWO_PI_Q30, TURN_ONE);
      x2 = qmul(x, x);
      t  = Q30_ONE;
      for (int k = 7; k >= 1; k--) begin
         t = Q30_ONE - sdiv(qmul(x2, t), longint'((2 * k) * (2 * k + 1)));
      end
      return qmul(x, t);
   endfunction

   // hamming-windowed sinc, normalized and scaled to q2.16
   function automatic coef_rom_type build_rom();
      coef_rom_type rom;
      longint h [TAPS];
      longint sum;
      longint an;
      longint raw;
      longint win;
      longint frac;
      longint wrap;
      longint num;
      longint c;
      int n;
      int unsigned ph;
      sum = 0;
      for (int i = 0; i < TAPS; i++) begin
         n  = i - (TAPS - 1) / 2;
         an = (n < 0) ? -longint'(n) : longint'(n);
         if (n == 0) begin
            raw = SINC_CENTER;
         end else begin
            frac = longint'(CUTOFF_HZ) * an;
            frac = frac - longint'(udiv(frac, 64'(OUTPUT_RATE_HZ))) * longint'(OUTPUT_RATE_HZ);
            ph   = 32'(udiv(frac << 32, 64'(OUTPUT_RATE_HZ)));
            raw  = sdiv(qmul(sin_turn(ph), INV_PI_Q30), an);
         end
         wrap = (i >= TAPS - 1) ? longint'(i - (TAPS - 1)) : longint'(i);
         ph   = 32'(udiv(wrap << 32, 64'(TAPS - 1)));
         win  = WIN_A_Q30 - qmul(WIN_B_Q30, sin_turn(ph + 32'h4000_0000));
         h[i] = qmul(raw, win);
         sum  = sum + h[i];
      end
      if (sum <= 0) begin
         sum = Q30_ONE;
      end
      for (int i = 0; i < TAPS; i++) begin
         num = h[i] * 64'sd65536;
         if (num >= 0) begin
            c = longint'(udiv(num + (sum >>> 1), sum));
         end else begin
            c = -longint'(udiv(-num + (sum >>> 1), sum));
         end
         if (c > COEF_MAX) begin
            c = COEF_MAX;
         end
         if (c < COEF_MIN) begin
            c = COEF_MIN;
         end
         rom[i] = COEF_W'(c);
      end
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_rom();

   // taps past the end of the filter read as zero
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] tap);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (int'(tap) < TAPS) begin
         c = COEF_ROM[tap[ROM_AW-1:0]];
      end
      return c;
   endfunction

endpackage

### hdl/fic_cell.sv
// fic_cell: one cell of the polyphase accumulation chain.
// holds one scaled history sample and adds its tap product to the passing sum.
// depends on fic_pkg.
`timescale 1ns / 1ps

module fic_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 shift,
   input  logic signed [fic_pkg::SCALED_W-1:0]  hist_in,
   output logic signed [fic_pkg::SCALED_W-1:0]  hist_out,
   input  fic_pkg::chain_type                   link_in,
   output fic_pkg::chain_type                   link_out
);
   import fic_pkg::*;

   logic signed [SCALED_W-1:0] hist_ff;
   logic signed [PROD_W-1:0]   hist_ext;
   logic signed [PROD_W-1:0]   coef_ext;
   logic signed [PROD_W-1:0]   prod;
   chain_type                  link_ff;
   chain_type                  link_in_next;

   assign hist_ext = PROD_W'(hist_ff);
   assign coef_ext = PROD_W'(coef_at(link_in.tap));
   assign prod     = hist_ext * coef_ext;

   always_comb begin
      link_in_next       = link_in;
      link_in_next.tap   = link_in.tap + TAP_W'(OVERSAMPLE_FACTOR);
      link_in_next.acc   = link_in.acc + ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (shift) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (advance) begin
         link_ff.valid <= link_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         link_ff.tap  <= link_in_next.tap;
         link_ff.last <= link_in_next.last;
         link_ff.eob  <= link_in_next.eob;
         link_ff.acc  <= link_in_next.acc;
      end
   end

   assign hist_out = hist_ff;
   assign link_out = link_ff;

endmodule

### hdl/fic_out_stage.sv
// fic_out_stage: rounding, saturation and the result register of the interpolator.
// holds one result transaction and throttles the chain through advance.
// depends on fic_pkg.
`timescale 1ns / 1ps

module fic_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  fic_pkg::chain_type            link,
   output logic                          advance,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fic_pkg::SAMPLE_W-1:0]  rsp_tdata,  // sample_out
   output logic                          rsp_tlast,  // last_of_run
   output logic                          rsp_tuser   // block_end
);
   import fic_pkg::*;

   localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1 << (FRAC_SHIFT - 1));
   localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W + 1)'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W:0] SAT_MIN  = -(ACC_W + 1)'(1 << (SAMPLE_W - 1));

   logic signed [ACC_W:0]    rounded;
   logic signed [ACC_W:0]    shifted;
   logic [SAMPLE_W-1:0]      sat_in;
   logic                     valid_ff;
   logic [SAMPLE_W-1:0]      data_ff;
   logic                     last_ff;
   logic                     user_ff;

   assign rounded = (ACC_W + 1)'(link.acc) + RND_BIAS;
   assign shifted = rounded >>> FRAC_SHIFT;

   always_comb begin
      if (shifted > SAT_MAX) begin
         sat_in = SAT_MAX[SAMPLE_W-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_in = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         sat_in = shifted[SAMPLE_W-1:0];
      end
   end

   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= sat_in;
         last_ff <= link.last;
         user_ff <= link.last & link.eob;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

### hdl/fir_interpolator_unit.sv
// fir_interpolator_unit: zero-stuffing fir interpolator built as a chain of mac cells.
// the sums for each input pass through the HIST_DEPTH cells and the output register;
// its OVERSAMPLE_FACTOR results come out on consecutive cycles without backpressure.
// a new input is taken only once the phase issue and the drain of the
// HIST_DEPTH-cell accumulation chain are done.
// reset: synchronous, clears the sample history, the phase counter and all valids.
`timescale 1ns / 1ps

module fir_interpolator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fic_pkg::SAMPLE_W-1:0]  req_tdata,  // sample_in
   input  logic                          req_tlast,  // end_of_block
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fic_pkg::SAMPLE_W-1:0]  rsp_tdata,  // sample_out
   output logic                          rsp_tlast,  // last_of_run
   output logic                          rsp_tuser   // block_end
);
   import fic_pkg::*;

   localparam logic signed [SCALED_W-1:0] L_MULT   = SCALED_W'(OVERSAMPLE_FACTOR);
   localparam logic [PHASE_W-1:0]         PHASE_LAST = PHASE_W'(OVERSAMPLE_FACTOR - 1);

   state_type                  state_ff;
   state_type                  state_in;
   logic [PHASE_W-1:0]         phase_ff;
   logic [PHASE_W-1:0]         phase_in;
   logic                       eob_ff;
   logic                       accept;
   logic                       advance;
   logic                       inject;
   logic                       chain_busy;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [SCALED_W-1:0] hist_chain [HIST_DEPTH+1];
   chain_type                  links [HIST_DEPTH+1];
   logic [HIST_DEPTH-1:0]      cell_valid;

   assign accept = req_tvalid && req_tready;
   assign scaled = SCALED_W'($signed(req_tdata)) * L_MULT;

   assign hist_chain[0] = scaled;

   always_comb begin
      links[0].valid = inject;
      links[0].tap   = TAP_W'(phase_ff);
      links[0].last  = (phase_ff == PHASE_LAST);
      links[0].eob   = eob_ff;
      links[0].acc   = '0;
   end

   for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
      fic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .shift    (accept),
         .hist_in  (hist_chain[k]),
         .hist_out (hist_chain[k+1]),
         .link_in  (links[k]),
         .link_out (links[k+1])
      );
      assign cell_valid[k] = links[k+1].valid;
   end

   assign chain_busy = |cell_valid;

   fic_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .link       (links[HIST_DEPTH]),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (advance && phase_ff == PHASE_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!chain_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      inject     = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ISSUE: inject     = 1'b1;
         ST_DRAIN: ;
         default:  ;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (inject && advance) begin
         phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         eob_ff <= req_tlast;
      end
   end

   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      accept |-> !chain_busy)
      else $error("input taken while the chain still holds sums");

   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ISSUE && phase_ff == '0)
      else $error("phase issue did not start at phase zero");

   a_user_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("block end flagged off the last result");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      int'(phase_ff) < OVERSAMPLE_FACTOR)
      else $error("phase counter out of range");

endmodule

### tb/sv/fir_interpolator_unit_tb.sv
// fir_interpolator_unit_tb: self-checking bench for the zero-stuffing fir interpolator.
// a directed table and then random segments go in over the req stream. each result is
// checked against an in-bench polyphase predictor. depends on fic_pkg and the unit.
`timescale 1ns / 1ps

module fir_interpolator_unit_tb;

   import fic_pkg::TAPS;
   import fic_pkg::OVERSAMPLE_FACTOR;
   import fic_pkg::HIST_DEPTH;
   import fic_pkg::SAMPLE_W;

   localparam int     CLOCK_HALF       = 6;
   localparam int     RESET_CYCLES     = 8;
   localparam int     RANDOM_ITEMS     = 480;
   localparam int     BURST_ITEMS      = 60;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     DRAIN_LIMIT      = 20000;
   localparam int     TAIL_CYCLES      = 32;
   localparam int     PRINT_LIMIT      = 50;
   localparam longint RUN_LIMIT_NS     = 64'd10_000_000;

   localparam longint ONE_Q30    = 64'sd1073741824;
   localparam longint TURN       = 64'sd4294967296;
   localparam longint RAD_Q30    = 64'sd6746518852;
   localparam longint RECIP_PI   = 64'sd341782638;
   localparam longint HAMMING_A  = 64'sd579820585;
   localparam longint HAMMING_B  = 64'sd493921239;
   localparam longint TAP_MAX    = 64'sd131071;
   localparam longint TAP_MIN    = -64'sd131072;
   localparam longint OUT_MAX    = 64'sd32767;
   localparam longint OUT_MIN    = -64'sd32768;

   localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

   typedef longint coef_table_t [TAPS];

   typedef enum logic [1:0] {
      SEG_NOISE,
      SEG_HOLD,
      SEG_SWING,
      SEG_QUIET
   } segment_kind_t;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       eob;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] typed_out;
   } stim_row_t;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       last_of_run;
      logic                       block_end;
   } out_rec_t;

   localparam int DIRECTED_ROWS = 25;

   // zero history gives zero output: first rows after reset and the row after the flush
   stim_row_t directed_rows [DIRECTED_ROWS] = '{
      '{16'sh0000, 1'b0, 1'b1, 16'sh0000},
      '{16'sh0000, 1'b1, 1'b1, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b1, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b0, 1'b0, 16'sh0000},
      '{16'sh8000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 1'b1, 1'b0, 16'sh0000},
      '{16'sh0001, 1'b0, 1'b0, 16'sh0000},
      '{16'shFFFF, 1'b1, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b0, 1'b0, 16'sh0000},
      '{16'sh0000, 1'b1, 1'b1, 16'sh0000}
   };

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;

   coef_table_t                filter_taps;
   logic signed [SAMPLE_W-1:0] sample_history [HIST_DEPTH];
   out_rec_t                   pending_outputs [$];
   int                         error_count       = 0;
   logic                       hold_off_pending  = 1'b0;
   logic                       steady_send       = 1'b0;

   fir_interpolator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_in
      .req_tlast  (req_tlast),   // end_of_block
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // sample_out
      .rsp_tlast  (rsp_tlast),   // last_of_run
      .rsp_tuser  (rsp_tuser)    // block_end
   );

   // q30 product, magnitudes rounded, sign put back
   function automatic longint mul_q30(input longint a, input longint b);
      logic            negative;
      longint unsigned mag_a;
      longint unsigned mag_b;
      longint unsigned prod;
      negative = (a < 0) != (b < 0);
      mag_a    = (a < 0) ? -a : a;
      mag_b    = (b < 0) ? -b : b;
      prod     = (mag_a * mag_b + (64'd1 << 29)) >> 30;
      return negative ? -longint'(prod) : longint'(prod);
   endfunction

   // sine of a 32-bit turn angle, q30, taylor series through x^15
   function automatic longint sine_turns(input logic [31:0] angle);
      logic [31:0] r;
      longint      s;
      longint      x;
      longint      x2;
      longint      t;
      r = angle;
      if (r >= 32'h4000_0000 && r < 32'hC000_0000) begin
         r = 32'h8000_0000 - r;
      end
      s  = longint'({{32{r[31]}}, r});
      x  = s * RAD_Q30 / TURN;
      x2 = mul_q30(x, x);
      t  = ONE_Q30;
      for (int k = 7; k >= 1; k--) begin
         t = ONE_Q30 - mul_q30(x2, t) / longint'((2 * k) * (2 * k + 1));
      end
      return mul_q30(x, t);
   endfunction

   // hamming-windowed sinc low-pass, normalized, q2.16
   function automatic coef_table_t lowpass_taps();
      coef_table_t c;
      longint      h [TAPS];
      longint      total;
      longint      mag_n;
      longint      raw;
      longint      win;
      longint      frac;
      longint      num;
      longint      q;
      logic [31:0] angle;
      int          n;
      total = 0;
      for (int i = 0; i < TAPS; i++) begin
         n     = i - (TAPS - 1) / 2;
         mag_n = (n < 0) ? -longint'(n) : longint'(n);
         if (n == 0) begin
            raw = 64'sd2 * longint'(fic_pkg::CUTOFF_HZ) * ONE_Q30
                  / longint'(fic_pkg::OUTPUT_RATE_HZ);
         end else begin
            frac  = (longint'(fic_pkg::CUTOFF_HZ) * mag_n) % longint'(fic_pkg::OUTPUT_RATE_HZ);
            angle = 32'((frac << 32) / longint'(fic_pkg::OUTPUT_RATE_HZ));
            raw   = mul_q30(sine_turns(angle), RECIP_PI) / mag_n;
         end
         angle = 32'((longint'(i % (TAPS - 1)) << 32) / longint'(TAPS - 1));
         angle = angle + 32'h4000_0000;
         win   = HAMMING_A - mul_q30(HAMMING_B, sine_turns(angle));
         h[i]  = mul_q30(raw, win);
         total = total + h[i];
      end
      if (total <= 0) begin
         total = ONE_Q30;
      end
      for (int i = 0; i < TAPS; i++) begin
         num = h[i] * 64'sd65536;
         if (num >= 0) begin
            q = (num + total / 2) / total;
         end else begin
            q = -((-num + total / 2) / total);
         end
         if (q > TAP_MAX) begin
            q = TAP_MAX;
         end
         if (q < TAP_MIN) begin
            q = TAP_MIN;
         end
         c[i] = q;
      end
      return c;
   endfunction

   // shift the sample in and queue the OVERSAMPLE_FACTOR polyphase outputs
   task automatic queue_expected(input logic signed [SAMPLE_W-1:0] sample, input logic eob,
                                 input logic typed, input logic signed [SAMPLE_W-1:0] typed_out);
      longint   acc;
      longint   y;
      int       idx;
      out_rec_t rec;
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         sample_history[k] = sample_history[k-1];
      end
      sample_history[0] = sample;
      for (int p = 0; p < OVERSAMPLE_FACTOR; p++) begin
         acc = 0;
         for (int k = 0; k < HIST_DEPTH; k++) begin
            idx = p + k * OVERSAMPLE_FACTOR;
            if (idx < TAPS) begin
               acc += longint'(sample_history[k]) * OVERSAMPLE_FACTOR * filter_taps[idx];
            end
         end
         y = (acc + 64'sd32768) >>> 16;
         if (y > OUT_MAX) begin
            y = OUT_MAX;
         end
         if (y < OUT_MIN) begin
            y = OUT_MIN;
         end
         rec.sample_out  = typed ? typed_out : SAMPLE_W'(y);
         rec.last_of_run = (p == OVERSAMPLE_FACTOR - 1);
         rec.block_end   = (p == OVERSAMPLE_FACTOR - 1) ? eob : 1'b0;
         pending_outputs.push_back(rec);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 19) < 17) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic int sender_gap();
      if (steady_send || $urandom_range(0, 2) != 0) begin
         return 0;
      end
      return gap_length();
   endfunction

   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] sample, input logic eob,
                               input logic typed, input logic signed [SAMPLE_W-1:0] typed_out,
                               input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= eob;
      do @(posedge clock); while (!req_tready);
      queue_expected(sample, eob, typed, typed_out);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("fir_interpolator_unit test failed");
      $finish;
   end

   // receiver: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int  stall_left;
      logic steady_recv;
      stall_left  = 0;
      steady_recv = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!steady_recv && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if ($urandom_range(0, 149) == 0) begin
            steady_recv = ~steady_recv;
         end
         @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      out_rec_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result transaction, data %h", rsp_tdata));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata !== want.sample_out) begin
               report_mismatch($sformatf("sample_out got %0d expected %0d",
                               $signed(rsp_tdata), want.sample_out));
            end
            if (rsp_tlast !== want.last_of_run) begin
               report_mismatch($sformatf("last_of_run got %b expected %b",
                               rsp_tlast, want.last_of_run));
            end
            if (rsp_tuser !== want.block_end) begin
               report_mismatch($sformatf("block_end got %b expected %b",
                               rsp_tuser, want.block_end));
            end
         end
      end
   end

   // stimulus
   initial begin
      segment_kind_t              seg_kind;
      int                         seg_left;
      logic signed [SAMPLE_W-1:0] seg_level;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       eob;
      int                         wait_cycles;
      filter_taps = lowpass_taps();
      for (int k = 0; k < HIST_DEPTH; k++) begin
         sample_history[k] = '0;
      end
      seg_kind  = SEG_NOISE;
      seg_left  = 0;
      seg_level = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_sample(directed_rows[i].sample, directed_rows[i].eob, directed_rows[i].typed,
                      directed_rows[i].typed_out, sender_gap());
      end

      // receiver holds off while the sender keeps offering back to back
      hold_off_pending = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            seg_kind  = segment_kind_t'($urandom_range(0, 3));
            seg_left  = $urandom_range(1, 12);
            seg_level = $urandom_range(0, 1) ? SAMPLE_W'($urandom)
                                             : ($urandom_range(0, 1) ? FULL_POS : FULL_NEG);
         end
         case (seg_kind)
            SEG_NOISE: begin
               sample = SAMPLE_W'($urandom);
            end
            SEG_HOLD: begin
               sample = seg_level;
            end
            SEG_SWING: begin
               sample = seg_left[0] ? FULL_POS : FULL_NEG;
            end
            default: begin
               sample = SAMPLE_W'($urandom_range(0, 511) - 256);
            end
         endcase
         seg_left--;
         eob = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 99) == 0) begin
            steady_send = ~steady_send;
         end
         offer_sample(sample, eob, 1'b0, '0, (n < BURST_ITEMS) ? 0 : sender_gap());
         // sender pause until the unit has delivered everything
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (pending_outputs.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (pending_outputs.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_outputs.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                         pending_outputs.size()));
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("fir_interpolator_unit test passed");
      end else begin
         $display("fir_interpolator_unit test failed");
      end
      $finish;
   end

endmodule
